// ===== rtl/servo_deadband_with_release_defines.svh =====
// assertion macros shared by the servo deadband rtl
`ifndef SERVO_DEADBAND_WITH_RELEASE_DEFINES_SVH
`define SERVO_DEADBAND_WITH_RELEASE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sdr_pkg.sv =====
// shared types and constants of the servo deadband block
package sdr_pkg;

	localparam int ANGLE_W     = 8;
	localparam int REQ_W       = 16;
	localparam int NOW_W       = 32;
	localparam int DELAY_W     = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 8'd180;

	// register indexes of the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MOVE_THRESHOLD = 8'd0,
		REG_RELEASE_DELAY  = 8'd1,
		REG_CLOSED_POS     = 8'd2,
		REG_OPEN_POS       = 8'd3
	} cfg_reg_t;

	localparam logic [ANGLE_W-1:0] RST_MOVE_THRESHOLD = 8'd5;
	localparam logic [DELAY_W-1:0] RST_RELEASE_DELAY  = 32'd1000;
	localparam logic [ANGLE_W-1:0] RST_CLOSED_POS     = 8'd0;
	localparam logic [ANGLE_W-1:0] RST_OPEN_POS       = 8'd180;

	typedef struct packed {
		logic [ANGLE_W-1:0] move_threshold;
		logic [DELAY_W-1:0] release_delay;
		logic [ANGLE_W-1:0] closed_pos;
		logic [ANGLE_W-1:0] open_pos;
	} cfg_t;

	typedef struct packed {
		logic               moved;
		logic [ANGLE_W-1:0] drive_angle;
		logic [ANGLE_W-1:0] move_delta;
		logic               drive_active;
		logic               released_now;
	} res_t;

endpackage

// ===== rtl/sdr_in_if.sv =====
// request channel: requested angle and timestamp
interface sdr_in_if;
	logic                        valid;
	logic                        ready;
	logic [sdr_pkg::REQ_W-1:0]   requested_angle;
	logic [sdr_pkg::NOW_W-1:0]   now_ms;

	modport source (output valid, requested_angle, now_ms, input ready);
	modport sink   (input valid, requested_angle, now_ms, output ready);
endinterface

// ===== rtl/sdr_out_if.sv =====
// result channel: move decision and drive status
interface sdr_out_if;
	logic                          valid;
	logic                          ready;
	logic                          moved;
	logic [sdr_pkg::ANGLE_W-1:0]   drive_angle;
	logic [sdr_pkg::ANGLE_W-1:0]   move_delta;
	logic                          drive_active;
	logic                          released_now;

	modport source (output valid, moved, drive_angle, move_delta, drive_active,
		released_now, input ready);
	modport sink   (input valid, moved, drive_angle, move_delta, drive_active,
		released_now, output ready);
endinterface

// ===== rtl/sdr_cfg_if.sv =====
// configuration write channel: register index and data
interface sdr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sdr_pkg::CFG_INDEX_W-1:0]  index;
	logic [sdr_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sdr_cfg_regs.sv =====
// configuration register file of the servo deadband block
module sdr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	sdr_cfg_if.sink       cfg,
	output sdr_pkg::cfg_t regs
);

	sdr_pkg::cfg_t regs_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.move_threshold <= sdr_pkg::RST_MOVE_THRESHOLD;
			regs_q.release_delay  <= sdr_pkg::RST_RELEASE_DELAY;
			regs_q.closed_pos     <= sdr_pkg::RST_CLOSED_POS;
			regs_q.open_pos       <= sdr_pkg::RST_OPEN_POS;
		end else if (cfg.valid) begin
			case (cfg.index)
				sdr_pkg::REG_MOVE_THRESHOLD: begin
					regs_q.move_threshold <= cfg.data[sdr_pkg::ANGLE_W-1:0];
				end
				sdr_pkg::REG_RELEASE_DELAY: begin
					regs_q.release_delay <= cfg.data[sdr_pkg::DELAY_W-1:0];
				end
				sdr_pkg::REG_CLOSED_POS: begin
					regs_q.closed_pos <= cfg.data[sdr_pkg::ANGLE_W-1:0];
				end
				sdr_pkg::REG_OPEN_POS: begin
					regs_q.open_pos <= cfg.data[sdr_pkg::ANGLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== rtl/sdr_engine.sv =====
// move decision, release timer and servo state of the deadband block
`include "servo_deadband_with_release_defines.svh"

module sdr_engine #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sdr_pkg::cfg_t               cfg,
	input  logic                        fire,
	input  logic [sdr_pkg::REQ_W-1:0]   req,
	input  logic [sdr_pkg::NOW_W-1:0]   now,
	output sdr_pkg::res_t               res
);

	localparam int CMP_W = (TIME_WIDTH > sdr_pkg::DELAY_W) ? TIME_WIDTH : sdr_pkg::DELAY_W;

	logic [sdr_pkg::ANGLE_W-1:0] last_request_q;
	logic                        has_request_q;
	logic [sdr_pkg::ANGLE_W-1:0] last_driven_q;
	logic                        has_driven_q;
	logic                        drive_on_q;
	logic [TIME_WIDTH-1:0]       move_time_q;

	logic [TIME_WIDTH-1:0]       now_tw;
	logic [TIME_WIDTH-1:0]       elapsed;
	logic                        expire;
	logic [sdr_pkg::ANGLE_W-1:0] target;
	logic                        changed;
	logic [sdr_pkg::ANGLE_W-1:0] delta;
	logic                        extreme;
	logic                        hold;
	logic                        moved;
	logic                        active;

	// wrapping time since the last move
	assign now_tw  = TIME_WIDTH'(now);
	assign elapsed = now_tw - move_time_q;
	assign expire  = drive_on_q && (CMP_W'(elapsed) >= CMP_W'(cfg.release_delay));

	// clamp and compare against history
	assign target  = (req > {8'd0, sdr_pkg::ANGLE_LIMIT}) ? sdr_pkg::ANGLE_LIMIT
		: req[sdr_pkg::ANGLE_W-1:0];
	assign changed = !has_request_q || (target != last_request_q);

	always_comb begin
		if (!has_driven_q) begin
			delta = sdr_pkg::ANGLE_LIMIT;
		end else if (target > last_driven_q) begin
			delta = target - last_driven_q;
		end else begin
			delta = last_driven_q - target;
		end
	end

	// deadband: small changes only move toward a newly requested end position
	assign extreme = (target == cfg.closed_pos) || (target == cfg.open_pos);
	assign hold    = has_driven_q &&
		(((delta < cfg.move_threshold) && !(extreme && changed)) ||
		 ((delta == '0) && !changed));
	assign moved   = !hold;
	assign active  = moved || (drive_on_q && !expire);

	always_comb begin
		res.moved        = moved;
		res.drive_angle  = moved ? target : last_driven_q;
		res.move_delta   = delta;
		res.drive_active = active;
		res.released_now = expire;
	end

	// history and drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_request_q <= '0;
			has_request_q  <= 1'b0;
			last_driven_q  <= '0;
			has_driven_q   <= 1'b0;
			drive_on_q     <= 1'b0;
			move_time_q    <= '0;
		end else if (fire) begin
			last_request_q <= target;
			has_request_q  <= 1'b1;
			drive_on_q     <= active;
			if (moved) begin
				last_driven_q <= target;
				has_driven_q  <= 1'b1;
				move_time_q   <= now_tw;
			end
		end
	end

	`SDR_ASSERT_NEXT(a_move_records_angle, fire && moved, has_driven_q && (last_driven_q == $past(target)), "move did not record target")
	`SDR_ASSERT_NEXT(a_move_records_time, fire && moved, drive_on_q && (move_time_q == $past(now_tw)), "move did not arm release timer")
	`SDR_ASSERT_NOW(a_first_request_moves, fire && !has_request_q, moved && (delta == sdr_pkg::ANGLE_LIMIT), "first request did not move")

endmodule

// ===== rtl/servo_deadband_with_release.sv =====
// Servo positioner with movement deadband and automatic drive release.
//
// Channels: request carries requested_angle and now_ms; result carries
// moved, drive_angle, move_delta, drive_active and released_now, one beat
// per request beat; cfg writes one of four registers by index (threshold,
// release delay, closed and open end positions); cfg is always ready.
// Path: a request beat is registered in the input register, then passes
// through the decision logic straight into the result register.
// Throughput: one beat per cycle unless result stalls; the servo history is
// updated in the same cycle an item enters res_s2, so the next item sees it.
// Stall: when result.ready is low the result register holds, the input
// register fills and then request.ready drops; nothing is lost or repeated.
// Reset: arst_n clears both stages and the servo history; registers return
// to threshold 5, delay 1000 ms, closed 0, open 180.
// Configuration must only be written with no beats in flight.
`include "servo_deadband_with_release_defines.svh"

module servo_deadband_with_release #(
	parameter int TIME_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sdr_in_if.sink     request,
	sdr_out_if.source  result,
	sdr_cfg_if.sink    cfg
);

	sdr_pkg::cfg_t              regs;
	sdr_pkg::res_t              res;
	logic                       valid_s1;
	logic [sdr_pkg::REQ_W-1:0]  req_s1;
	logic [sdr_pkg::NOW_W-1:0]  now_s1;
	logic                       valid_s2;
	sdr_pkg::res_t              res_s2;
	logic                       s2_free;
	logic                       advance;

	sdr_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// handshake between the two stages
	assign s2_free       = !valid_s2 || result.ready;
	assign advance       = valid_s1 && s2_free;
	assign request.ready = !valid_s1 || s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			req_s1 <= request.requested_angle;
			now_s1 <= request.now_ms;
		end
	end

	sdr_engine #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (regs),
		.fire   (advance),
		.req    (req_s1),
		.now    (now_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid        = valid_s2;
	assign result.moved        = res_s2.moved;
	assign result.drive_angle  = res_s2.drive_angle;
	assign result.move_delta   = res_s2.move_delta;
	assign result.drive_active = res_s2.drive_active;
	assign result.released_now = res_s2.released_now;

	`SDR_ASSERT_NEXT(a_stalled_item_kept, valid_s1 && !s2_free, valid_s1, "held request beat dropped")
	`SDR_ASSERT_NEXT(a_advance_fills_output, advance, valid_s2, "advanced beat missing at output")

endmodule
